>>> design/jfst_pkg.sv
// ----------------------------------------------------------------------------
// jfst_pkg: shared definitions for the job FIFO service timer
// Queue sizing, field widths, request codes and the wait-queue entry type.
// ----------------------------------------------------------------------------
package jfst_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PAGE_BITS   = 12;

  localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 20;
  localparam int SPP_W    = 16;
  localparam int PROD_W   = PAGE_BITS + SPP_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SECS_W   = SUM_W - 8;

  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_LAST     = {ID_W{1'b1}};
  localparam logic [SPP_W-1:0] SPP_RESET   = SPP_W'(512);
  localparam logic [SPP_W-1:0] SPP_MIN     = SPP_W'(1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PAGE_BITS-1:0] pages;
    logic [TIME_W-1:0]    submit;
  } entry_t;

  // Per-cycle commands broadcast to every queue cell.
  typedef struct packed {
    logic            add;
    logic            pop;
    logic            cancel;
    logic [ID_W-1:0] cancel_id;
  } cell_ctl_t;

endpackage

>>> design/jfst_cell.sv
// ----------------------------------------------------------------------------
// jfst_cell: one slot of the wait queue
// Holds one entry, loads the new one when an add fills this first free slot,
// and takes its right neighbor's entry when the queue closes up at or before it.
// ----------------------------------------------------------------------------
module jfst_cell (
  input  logic                         clk,
  input  logic [jfst_pkg::QIDX_W-1:0]  idx,
  input  logic [jfst_pkg::FILL_W-1:0]  fill,
  input  jfst_pkg::cell_ctl_t          ctl,
  input  jfst_pkg::entry_t             new_entry,
  input  jfst_pkg::entry_t             right_entry,
  input  logic                         hit_in,
  output jfst_pkg::entry_t             entry,
  output logic                         hit_out
);

  logic occupied;
  logic match;
  logic load;
  logic shift;

  assign occupied = ({1'b0, idx} < fill);
  assign match    = ctl.cancel && occupied && (entry.id == ctl.cancel_id);
  assign hit_out  = hit_in || match;
  assign load     = ctl.add && ({1'b0, idx} == fill);
  assign shift    = ctl.pop || (ctl.cancel && hit_out);

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= new_entry;
    end else if (shift) begin
      entry <= right_entry;
    end
  end

endmodule

>>> design/jfst_queue.sv
// ----------------------------------------------------------------------------
// jfst_queue: wait queue built as a row of cells
// Slot 0 is the head. A cancel step removes the first matching entry by
// shifting every slot from that point one place toward the head.
// ----------------------------------------------------------------------------
module jfst_queue (
  input  logic                         clk,
  input  logic [jfst_pkg::FILL_W-1:0]  fill,
  input  jfst_pkg::cell_ctl_t          ctl,
  input  jfst_pkg::entry_t             new_entry,
  output jfst_pkg::entry_t             head,
  output logic                         any_hit
);

  jfst_pkg::entry_t entries [jfst_pkg::QUEUE_DEPTH+1];
  logic             hits    [jfst_pkg::QUEUE_DEPTH+1];

  assign hits[0]                      = 1'b0;
  assign entries[jfst_pkg::QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < jfst_pkg::QUEUE_DEPTH; i++) begin : g_cell
    jfst_cell u_cell (
      .clk         (clk),
      .idx         (jfst_pkg::QIDX_W'(i)),
      .fill        (fill),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .right_entry (entries[i+1]),
      .hit_in      (hits[i]),
      .entry       (entries[i]),
      .hit_out     (hits[i+1])
    );
  end

  assign head    = entries[0];
  assign any_hit = hits[jfst_pkg::QUEUE_DEPTH];

endmodule

>>> design/job_fifo_service_timer.sv
// ----------------------------------------------------------------------------
// job_fifo_service_timer: job server with a FIFO wait queue and a tick clock
// Adds, cancels and serves print jobs, one request item at a time.
// ----------------------------------------------------------------------------
// Usage. Request items arrive on the s_ stream: s_tuser carries the request
// type (add, cancel, tick), s_tdata the page count and the cancel id. Every
// request produces exactly one result item on the m_ stream, carrying the
// request outcome, any start or finish event of this tick, and the server
// status after the request. The seconds-per-page register is written through
// cfg_we and cfg_wdata, and the user must write it only while the block is
// idle, which the block itself does not enforce; a written zero becomes 1.
// Timing. s_tready is high only between requests. After the accepting edge,
// an add, a no-op or an idle tick passes S_EXEC and then S_OUT, a tick of a
// running job passes S_EXEC, S_COUNT and S_OUT, and a tick that starts a job
// also passes S_LOAD after S_EXEC for the registered page multiply. The
// result register is loaded as S_OUT is left. A cancel repeats S_EXEC once
// per removed entry and once more, as each step of the cell row closes one
// gap. The next request is taken in the cycle after the result is in the
// output register, even if the receiver has not yet taken it; a further
// result then waits in its final state until m_tready frees the register.
//
// Reset (rst, synchronous) empties the queue, clears the clock and the
// server, sets the next id to 1 and the register to 2.0 seconds per page.
// ----------------------------------------------------------------------------
module job_fifo_service_timer (
  input  logic         clk,
  input  logic         rst,
  // Configuration: seconds per page, unsigned Q8.8.
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // page_count[11:0], cancel_id[27:12], zero pad
  input  logic [1:0]   s_tuser,   // req_type[1:0]
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata    // accepted[0], assigned_id[16:1],
                                  // start_event[17], start_job[33:18],
                                  // finish_event[34], finish_job[50:35],
                                  // wait_secs[82:51], run_secs[114:83],
                                  // server_busy[115], remaining_secs[135:116],
                                  // now_secs[167:136]
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;

  // Latched request.
  logic [1:0]                        req;
  logic [jfst_pkg::PAGE_BITS-1:0]    req_pages;
  logic [jfst_pkg::ID_W-1:0]         req_cid;

  // Server state.
  logic [jfst_pkg::FILL_W-1:0]       fill;
  logic [jfst_pkg::TIME_W-1:0]       clock_secs;
  logic [jfst_pkg::ID_W-1:0]         next_id;
  logic                              serving;
  logic [jfst_pkg::CNT_W-1:0]        countdown;
  logic [jfst_pkg::ID_W-1:0]         cur_id;
  logic [jfst_pkg::TIME_W-1:0]       cur_submit;
  logic [jfst_pkg::TIME_W-1:0]       cur_start;
  logic [jfst_pkg::SPP_W-1:0]        spp;
  logic [jfst_pkg::PROD_W-1:0]       prod;

  // Result fields collected while the request runs.
  logic                              r_acc;
  logic [jfst_pkg::ID_W-1:0]         r_assigned;
  logic                              r_st_ev;
  logic [jfst_pkg::ID_W-1:0]         r_st_job;
  logic                              r_fin_ev;
  logic [jfst_pkg::ID_W-1:0]         r_fin_job;
  logic [jfst_pkg::TIME_W-1:0]       r_wait;
  logic [jfst_pkg::TIME_W-1:0]       r_run;

  // Queue interface.
  jfst_pkg::cell_ctl_t               ctl;
  jfst_pkg::entry_t                  new_entry;
  jfst_pkg::entry_t                  head;
  logic                              any_hit;

  logic                              in_fire;
  logic                              out_free;
  logic                              add_ok;
  logic [jfst_pkg::SUM_W-1:0]        svc_sum;
  logic [jfst_pkg::SECS_W-1:0]       svc_secs;
  logic [jfst_pkg::CNT_W-1:0]        svc_time;
  logic [jfst_pkg::TIME_W-1:0]       clock_inc;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign add_ok   = (fill < jfst_pkg::FILL_W'(jfst_pkg::QUEUE_DEPTH));
  assign clock_inc = clock_secs + jfst_pkg::TIME_W'(1);

  // Commands to the cell row. A cancel runs one removal per cycle until no
  // occupied slot holds the id any more.
  always_comb begin
    ctl.add       = (state == S_EXEC) && (req == jfst_pkg::REQ_ADD) && add_ok;
    ctl.pop       = (state == S_EXEC) && (req == jfst_pkg::REQ_TICK) && !serving &&
                    (fill != '0);
    ctl.cancel    = (state == S_EXEC) && (req == jfst_pkg::REQ_CANCEL);
    ctl.cancel_id = req_cid;
  end

  assign new_entry.id     = next_id;
  assign new_entry.pages  = req_pages;
  assign new_entry.submit = clock_secs;

  jfst_queue u_queue (
    .clk       (clk),
    .fill      (fill),
    .ctl       (ctl),
    .new_entry (new_entry),
    .head      (head),
    .any_hit   (any_hit)
  );

  // Ceiling of the Q8.8 product, saturated to the countdown width.
  assign svc_sum  = {1'b0, prod} + jfst_pkg::SUM_W'(255);
  assign svc_secs = svc_sum[jfst_pkg::SUM_W-1:8];
  assign svc_time = (32'(svc_secs) > 32'(jfst_pkg::COUNT_MAX)) ? jfst_pkg::COUNT_MAX
                                                                : jfst_pkg::CNT_W'(svc_secs);

  always_ff @(posedge clk) begin
    if (rst) begin
      spp <= jfst_pkg::SPP_RESET;
    end else if (cfg_we) begin
      spp <= (cfg_wdata == '0) ? jfst_pkg::SPP_MIN : cfg_wdata;
    end
  end

  // Request latch and result accumulators; payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req        <= s_tuser;
      req_pages  <= jfst_pkg::PAGE_BITS'(s_tdata[11:0]);
      req_cid    <= s_tdata[27:12];
      r_acc      <= 1'b0;
      r_assigned <= '0;
      r_st_ev    <= 1'b0;
      r_st_job   <= '0;
      r_fin_ev   <= 1'b0;
      r_fin_job  <= '0;
      r_wait     <= '0;
      r_run      <= '0;
    end else begin
      if (state == S_EXEC) begin
        case (req)
          jfst_pkg::REQ_ADD: begin
            if (add_ok) begin
              r_acc      <= 1'b1;
              r_assigned <= next_id;
            end
          end
          jfst_pkg::REQ_CANCEL: begin
            if (any_hit) begin
              r_acc <= 1'b1;
            end
          end
          jfst_pkg::REQ_TICK: begin
            r_acc <= 1'b1;
            if (ctl.pop) begin
              r_st_ev  <= 1'b1;
              r_st_job <= head.id;
            end
          end
          default: begin
          end
        endcase
      end
      if ((state == S_COUNT) && (countdown <= jfst_pkg::CNT_W'(1))) begin
        r_fin_ev  <= 1'b1;
        r_fin_job <= cur_id;
        r_wait    <= cur_start - cur_submit;
        r_run     <= clock_inc - cur_start;
      end
    end
    if (ctl.pop) begin
      prod <= head.pages * spp;
    end
  end

  // Sequencer and server state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      clock_secs <= '0;
      next_id    <= jfst_pkg::ID_W'(1);
      serving    <= 1'b0;
      countdown  <= '0;
      cur_id     <= '0;
      cur_submit <= '0;
      cur_start  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (req)
            jfst_pkg::REQ_ADD: begin
              if (add_ok) begin
                fill    <= fill + jfst_pkg::FILL_W'(1);
                next_id <= (next_id == jfst_pkg::ID_LAST) ? jfst_pkg::ID_W'(1)
                                                          : next_id + jfst_pkg::ID_W'(1);
              end
              state <= S_OUT;
            end
            jfst_pkg::REQ_CANCEL: begin
              if (any_hit) begin
                fill <= fill - jfst_pkg::FILL_W'(1);
              end else begin
                state <= S_OUT;
              end
            end
            jfst_pkg::REQ_TICK: begin
              if (serving) begin
                state <= S_COUNT;
              end else if (fill != '0) begin
                cur_id     <= head.id;
                cur_submit <= head.submit;
                cur_start  <= clock_secs;
                fill       <= fill - jfst_pkg::FILL_W'(1);
                serving    <= 1'b1;
                state      <= S_LOAD;
              end else begin
                clock_secs <= clock_inc;
                state      <= S_OUT;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_LOAD: begin
          countdown <= svc_time;
          state     <= S_COUNT;
        end
        S_COUNT: begin
          clock_secs <= clock_inc;
          if (countdown <= jfst_pkg::CNT_W'(1)) begin
            countdown <= '0;
            serving   <= 1'b0;
          end else begin
            countdown <= countdown - jfst_pkg::CNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= {clock_secs, countdown, serving, r_run, r_wait, r_fin_job, r_fin_ev,
                  r_st_job, r_st_ev, r_assigned, r_acc};
    end
  end

  // The queue never holds more entries than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= jfst_pkg::FILL_W'(jfst_pkg::QUEUE_DEPTH))
    else $error("queue fill above depth");

  // An idle server always shows a zero countdown.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !serving |-> (countdown == '0))
    else $error("countdown nonzero while idle");

  // Id zero is never handed out.
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("next id is zero");

  // A result leaving its final state always lands in the output register.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_free) |=> (m_tvalid && (state == S_IDLE)))
    else $error("result not presented");

endmodule
